// ----- rtl/bpc_pkg.sv -----
// Package for the barometric pressure compensation block.
// Holds status codes, state machine type and controller/datapath command structs.
package bpc_pkg;

    localparam int unsigned DivStepW = 6;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TEMP_HELD = 2'd1,
        ST_PRES_HELD = 2'd2,
        ST_TDIV_ZERO = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TX1,
        S_TDEN,
        S_TDIV,
        S_TB5,
        S_PB6,
        S_PSQ,
        S_PMUL,
        S_PB4,
        S_PB7,
        S_PDIV,
        S_PFIN1,
        S_PFIN2,
        S_OUT
    } t_state;

    // Controller-to-datapath commands: one step per cycle, held while waiting.
    typedef struct packed {
        logic   load;
        t_state step;
        logic   div_start;
        logic   emit;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic ut_zero;
        logic div_busy;
    } t_stat;

endpackage

// ----- rtl/barometric_pressure_compensation.sv -----
// Top level of barometric pressure compensation: APB registers, controller, datapath.
// Depends on bpc_pkg, bpc_ctrl, bpc_datapath.
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata: raw_temp[15:0], raw_pressure[34:16]
//  m_axis    out  tvalid/tready        tdata: temp_tenths, pressure_pa, status
//  apb       in   psel/penable/pwrite  6 registers at 4*i
// The result time is set mostly by two passes of the shared 32-bit divider;
// when raw_temp is zero the temperature pass is skipped.
// The next input is accepted only back in S_IDLE, once the result has been registered.
// A finished item stalls until the previous result transaction has been taken.
// Reset is synchronous, clears registers, state and held terms.
module barometric_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // raw_temp[15:0], raw_pressure[34:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // temp_tenths[15:0], pressure_pa[47:16], status[49:48]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
    logic [1:0]  r_oss;
    bpc_pkg::t_cmd  w_cmd;
    bpc_pkg::t_stat w_stat;
    logic [15:0] w_t;
    logic [31:0] w_p;
    logic [1:0]  w_s;

    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac12 <= '0; r_ac34 <= '0; r_ac56 <= '0;
            r_b12 <= '0; r_mcmd <= '0; r_oss <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                5'd0:  r_ac12 <= pwdata;
                5'd4:  r_ac34 <= pwdata;
                5'd8:  r_ac56 <= pwdata;
                5'd12: r_b12  <= pwdata;
                5'd16: r_mcmd <= pwdata;
                5'd20: r_oss  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            5'd0:  prdata = r_ac12;
            5'd4:  prdata = r_ac34;
            5'd8:  prdata = r_ac56;
            5'd12: prdata = r_b12;
            5'd16: prdata = r_mcmd;
            5'd20: prdata = {30'd0, r_oss};
            default: prdata = '0;
        endcase
    end

    bpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    bpc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .i_raw_temp(s_axis_tdata[15:0]), .i_raw_pressure(s_axis_tdata[34:16]),
        .i_ac12(r_ac12), .i_ac34(r_ac34), .i_ac56(r_ac56),
        .i_b12(r_b12), .i_mcmd(r_mcmd), .i_oss(r_oss),
        .o_temp_tenths(w_t), .o_pressure_pa(w_p), .o_status(w_s)
    );

    assign m_axis_tdata = {6'd0, w_s, w_p, w_t};
endmodule

// ----- rtl/bpc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, 32 bits.
// Depends on bpc_pkg for widths.
module bpc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    logic [31:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [bpc_pkg::DivStepW-1:0] r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;

    assign w_trial = {r_rem[31:0], r_quot[31]};

    // Shift one quotient bit in per cycle.
    always_comb begin
        n_rem  = w_trial;
        n_quot = {r_quot[30:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 6'd31) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

// ----- rtl/bpc_datapath.sv -----
// Datapath for barometric compensation: calibration, shared multiplier steps, divider.
// Depends on bpc_pkg and bpc_div.
module bpc_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpc_pkg::t_cmd   i_cmd,
    output bpc_pkg::t_stat  o_stat,
    input  logic [15:0]     i_raw_temp,
    input  logic [18:0]     i_raw_pressure,
    input  logic [31:0]     i_ac12,
    input  logic [31:0]     i_ac34,
    input  logic [31:0]     i_ac56,
    input  logic [31:0]     i_b12,
    input  logic [31:0]     i_mcmd,
    input  logic [1:0]      i_oss,
    output logic [15:0]     o_temp_tenths,
    output logic [31:0]     o_pressure_pa,
    output logic [1:0]      o_status
);
    logic signed [31:0] r_ut, r_up;
    logic signed [31:0] r_b5, r_lastp;
    logic signed [31:0] r_x1, r_den, r_b6, r_sq, r_a, r_b, r_c, r_d, r_b3, r_b4, r_b7, r_p;
    logic               r_tneg, r_pshift;
    logic [1:0]         r_status;
    logic [15:0]        r_tout;
    logic [15:0]        r_otemp;
    logic [31:0]        r_opres;
    logic [1:0]         r_ostat;

    logic signed [15:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [15:0]        w_ac4, w_ac5, w_ac6;
    logic signed [31:0] w_sum, w_t;
    logic [31:0]        w_num, w_den, w_q;
    logic [31:0]        w_mc2k;
    logic               w_busy;
    logic signed [63:0] w_mab;
    logic signed [31:0] w_ab, w_mcd, w_pq, w_lastp_n;
    logic [1:0]         w_status_n;

    assign w_ac1 = i_ac12[31:16]; assign w_ac2 = i_ac12[15:0];
    assign w_ac3 = i_ac34[31:16]; assign w_ac4 = i_ac34[15:0];
    assign w_ac5 = i_ac56[31:16]; assign w_ac6 = i_ac56[15:0];
    assign w_b1  = i_b12[31:16];  assign w_b2  = i_b12[15:0];
    assign w_mc  = i_mcmd[31:16]; assign w_md  = i_mcmd[15:0];
    assign w_mc2k = {{5{w_mc[15]}}, w_mc, 11'd0};

    // Two shared 32x32 multipliers, operands staged in r_a..r_d.
    assign w_mab = r_a * r_b;
    assign w_ab  = w_mab[31:0];
    assign w_mcd = r_c * r_d;

    // Divider operands: magnitudes for the temperature step, unsigned b7 and b4 for pressure.
    always_comb begin
        w_num = '0;
        w_den = '0;
        if (i_cmd.step == bpc_pkg::S_TDIV) begin
            w_num = w_mc2k[31] ? -w_mc2k : w_mc2k;
            w_den = r_den[31] ? -r_den : r_den;
        end else begin
            w_num = r_pshift ? r_b7 : {r_b7[30:0], 1'b0};
            w_den = r_b4;
        end
    end

    bpc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_busy (w_busy),
        .o_quot (w_q)
    );

    assign w_sum = r_b5 + 32'sd8;
    assign w_t   = w_sum >>> 4;

    // Raw pressure quotient, doubled back when the numerator was not pre-doubled.
    assign w_pq = r_pshift ? {w_q[30:0], 1'b0} : w_q;

    // Final pressure and status of the transaction.
    assign w_lastp_n = (r_b4 != 32'sd0) ?
                       r_p + (((w_ab >>> 16) + r_x1 + 32'sd3791) >>> 4) : r_lastp;

    always_comb begin
        w_status_n = r_status;
        if (r_b4 == 32'sd0 && r_status != bpc_pkg::ST_TDIV_ZERO) begin
            w_status_n = bpc_pkg::ST_PRES_HELD;
        end
    end

    // Step through the datapath under controller command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5     <= '0;
            r_lastp  <= '0;
            r_status <= bpc_pkg::ST_OK;
        end else begin
            unique case (i_cmd.step)
                bpc_pkg::S_IDLE: begin
                    if (i_cmd.load) begin
                        r_ut     <= {16'd0, i_raw_temp};
                        r_up     <= {13'd0, i_raw_pressure};
                        r_status <= (i_raw_temp == 16'd0) ? bpc_pkg::ST_TEMP_HELD
                                                          : bpc_pkg::ST_OK;
                        r_a <= {16'd0, i_raw_temp} - {16'd0, w_ac6};
                        r_b <= {16'd0, w_ac5};
                    end
                end
                bpc_pkg::S_TX1: begin
                    // (UT-AC6)*AC5 fits 33 bits signed; floor shift by 15.
                    r_x1 <= 32'(w_mab >>> 15);
                end
                bpc_pkg::S_TDEN: begin
                    r_den  <= r_x1 + 32'(w_md);
                    r_tneg <= 1'b0;
                end
                bpc_pkg::S_TDIV: begin
                    r_tneg <= w_mc2k[31] ^ r_den[31];
                end
                bpc_pkg::S_TB5: begin
                    if (r_status == bpc_pkg::ST_OK) begin
                        if (r_den == 32'sd0) r_status <= bpc_pkg::ST_TDIV_ZERO;
                        else r_b5 <= r_x1 + (r_tneg ? -w_q : w_q);
                    end
                end
                bpc_pkg::S_PB6: begin
                    r_b6 <= r_b5 - 32'sd4000;
                    r_a  <= r_b5 - 32'sd4000;
                    r_b  <= r_b5 - 32'sd4000;
                    r_c  <= 32'(w_ac2);
                    r_d  <= r_b5 - 32'sd4000;
                    if (w_t > 32'sd32767)        r_tout <= 16'h7fff;
                    else if (w_t < -32'sd32768)  r_tout <= 16'h8000;
                    else                         r_tout <= w_t[15:0];
                end
                bpc_pkg::S_PSQ: begin
                    r_sq <= w_ab >>> 12;
                    r_x1 <= w_mcd >>> 11;                     // x2 = ac2*b6 >> 11
                    r_a  <= 32'(w_ac3);
                    r_b  <= r_b6;
                end
                bpc_pkg::S_PMUL: begin
                    r_c  <= 32'(w_b2);
                    r_d  <= r_sq;
                    r_den <= w_ab >>> 13;                     // ac3*b6
                    r_a  <= 32'(w_b1);
                    r_b  <= r_sq;
                end
                bpc_pkg::S_PB4: begin
                    // b3 from x1=b2*sq>>11 plus ac2 term
                    r_b3 <= (((32'(w_ac1) <<< 2) + (w_mcd >>> 11) + r_x1) << i_oss)
                            + 32'sd2 >>> 2;
                    r_a  <= {16'd0, w_ac4};
                    r_b  <= ((r_den + (w_ab >>> 16) + 32'sd2) >>> 2) + 32'sd32768;
                end
                bpc_pkg::S_PB7: begin
                    r_b4 <= 32'(w_mab[31:0] >> 15);
                    r_c  <= r_up - r_b3;
                    r_d  <= 32'(17'd50000 >> i_oss);
                end
                bpc_pkg::S_PDIV: begin
                    r_b7     <= w_mcd;
                    r_pshift <= w_mcd[31];
                end
                bpc_pkg::S_PFIN1: begin
                    r_p <= w_pq;
                    r_a <= w_pq >>> 8;
                    r_b <= w_pq >>> 8;
                    r_c <= -32'sd7357;
                    r_d <= w_pq;
                end
                bpc_pkg::S_PFIN2: begin
                    r_a <= w_ab;
                    r_b <= 32'sd3038;
                    r_x1 <= w_mcd >>> 16;
                end
                bpc_pkg::S_OUT: begin
                    r_lastp  <= w_lastp_n;
                    r_status <= w_status_n;
                end
                default: ;
            endcase
        end
    end

    // Hold the finished transaction for the result side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otemp <= '0;
            r_opres <= '0;
            r_ostat <= bpc_pkg::ST_OK;
        end else if (i_cmd.emit) begin
            r_otemp <= r_tout;
            r_opres <= w_lastp_n;
            r_ostat <= w_status_n;
        end
    end

    assign o_stat.ut_zero   = (r_ut == 32'sd0);
    assign o_stat.div_busy  = w_busy;
    assign o_temp_tenths = r_otemp;
    assign o_pressure_pa = r_opres;
    assign o_status      = r_ostat;
endmodule

// ----- rtl/bpc_ctrl.sv -----
// Controller state machine for barometric compensation.
// Depends on bpc_pkg; drives bpc_datapath by command struct.
module bpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  bpc_pkg::t_stat i_stat,
    output bpc_pkg::t_cmd  o_cmd
);
    bpc_pkg::t_state r_state, n_state;
    logic r_ovalid, r_wait;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpc_pkg::S_IDLE:  if (i_in_valid) n_state = bpc_pkg::S_TX1;
            bpc_pkg::S_TX1:   n_state = i_stat.ut_zero ? bpc_pkg::S_PB6 : bpc_pkg::S_TDEN;
            bpc_pkg::S_TDEN:  n_state = bpc_pkg::S_TDIV;
            bpc_pkg::S_TDIV:  if (r_wait && !i_stat.div_busy) n_state = bpc_pkg::S_TB5;
            bpc_pkg::S_TB5:   n_state = bpc_pkg::S_PB6;
            bpc_pkg::S_PB6:   n_state = bpc_pkg::S_PSQ;
            bpc_pkg::S_PSQ:   n_state = bpc_pkg::S_PMUL;
            bpc_pkg::S_PMUL:  n_state = bpc_pkg::S_PB4;
            bpc_pkg::S_PB4:   n_state = bpc_pkg::S_PB7;
            bpc_pkg::S_PB7:   n_state = bpc_pkg::S_PDIV;
            bpc_pkg::S_PDIV:  n_state = bpc_pkg::S_PFIN1;
            bpc_pkg::S_PFIN1: if (r_wait && !i_stat.div_busy) n_state = bpc_pkg::S_PFIN2;
            bpc_pkg::S_PFIN2: n_state = bpc_pkg::S_OUT;
            bpc_pkg::S_OUT:   if (!r_ovalid || i_out_ready) n_state = bpc_pkg::S_IDLE;
            default:          n_state = bpc_pkg::S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd.step      = r_state;
        o_cmd.load      = (r_state == bpc_pkg::S_IDLE) && i_in_valid;
        o_cmd.div_start = ((r_state == bpc_pkg::S_TDIV) || (r_state == bpc_pkg::S_PFIN1))
                          && !r_wait;
        o_cmd.emit      = (r_state == bpc_pkg::S_OUT) && (!r_ovalid || i_out_ready);
        o_in_ready      = (r_state == bpc_pkg::S_IDLE);
        o_out_valid     = r_ovalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpc_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= (n_state == r_state);
            if (o_cmd.emit)       r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == bpc_pkg::S_IDLE)) else $error("ready outside idle");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpc_pkg::S_OUT) |=> r_ovalid) else $error("result lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> r_ovalid) else $error("result dropped");
`endif
endmodule
